@@ rtl/nfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared types, constants and helpers for the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int FIELD_W   = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [WORD_BITS-1:0] bitmap_word_t;
    typedef logic [BIT_W-1:0]     bit_pos_t;
    typedef logic [FIELD_W-1:0]   slot_field_t;

    // lowest set bit of a bitmap word
    function automatic bit_pos_t first_set(input bitmap_word_t w);
        bit_pos_t pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/nfsa_ram.sv @@
// ----------------------------------------------------------------------------
// nfsa_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module nfsa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/next_fit_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_unit
// Next-fit slot allocator over a pool of SLOT_COUNT buffer slots.
// ----------------------------------------------------------------------------
// The in-use bitmap sits in a RAM of 32-bit words, one bit per slot, beside a
// hint cursor. After reset a clearing pass writes one word per cycle, so no
// request is taken until every word is clear. One request is worked at a
// time. A free reads its word, writes it back with the bit cleared, then
// loads the output; an out-of-range free skips the RAM. An allocate reads
// one bitmap word per cycle from the cursor's word: from one word on a hit
// up to ceil(SLOT_COUNT/32) + 1 words when the pool is exhausted. The RAM's
// single read port sets the one-word-per-cycle scan speed. A result waiting on
// m_tready holds the output register; the next request may be taken meanwhile.
module next_fit_slot_allocator_unit #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] slot_to_free, [15:10] zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [9:0] granted_slot, [10] success,
                                   // [11] hit_at_cursor, [15:12] zero
);
    import nfsa_pkg::*;

    localparam int WORDS     = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW        = AW + BIT_W;
    localparam int LAST_BITS = SLOT_COUNT - (WORDS - 1) * WORD_BITS;

    localparam logic [AW-1:0] LAST_ADDR    = AW'(WORDS - 1);
    localparam logic [AW:0]   WORDS_C      = (AW + 1)'(WORDS);
    localparam logic [SW:0]   SLOT_COUNT_C = (SW + 1)'(SLOT_COUNT);
    localparam bitmap_word_t  LAST_MASK    = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam bitmap_word_t  ONE_BIT      = {{(WORD_BITS - 1){1'b0}}, 1'b1};

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FREE  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [SW-1:0] cursor_reg, cursor_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic [AW:0]   scan_cnt_reg, scan_cnt_next;
    slot_field_t   res_slot_reg, res_slot_next;
    logic          res_ok_reg, res_ok_next;
    logic          res_hit_reg, res_hit_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [15:0]   m_tdata_reg, m_tdata_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    bitmap_word_t  ram_wdata;
    logic [AW-1:0] ram_raddr;
    bitmap_word_t  ram_rdata;

    logic          in_range;
    bitmap_word_t  free_bits, cand;
    bit_pos_t      pos, cur_bit;
    logic [SW-1:0] found_slot;
    logic [SW:0]   found_inc;
    logic [AW-1:0] wrap_addr;

    nfsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .ADDR_W(AW)
    ) u_bitmap (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_range   = 32'(s_tdata[FIELD_W-1:0]) < 32'(SLOT_COUNT);
    assign cur_bit    = cursor_reg[BIT_W-1:0];
    assign free_bits  = ~ram_rdata & ((cur_addr_reg == LAST_ADDR) ? LAST_MASK : '1);
    assign pos        = first_set(cand);
    assign found_slot = {cur_addr_reg, pos};
    assign found_inc  = {1'b0, found_slot} + 1'b1;
    assign wrap_addr  = (cur_addr_reg == LAST_ADDR) ? '0 : cur_addr_reg + 1'b1;

    always_comb begin
        if (scan_cnt_reg == '0) begin
            cand = free_bits & ({WORD_BITS{1'b1}} << cur_bit);
        end else if (scan_cnt_reg == WORDS_C) begin
            cand = free_bits & ~({WORD_BITS{1'b1}} << cur_bit);
        end else begin
            cand = free_bits;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cursor_next   = cursor_reg;
        slot_next     = slot_reg;
        cur_addr_next = cur_addr_reg;
        scan_cnt_next = scan_cnt_reg;
        res_slot_next = res_slot_reg;
        res_ok_next   = res_ok_reg;
        res_hit_next  = res_hit_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = cur_addr_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_slot_next = '0;
                    res_ok_next   = 1'b0;
                    res_hit_next  = 1'b0;
                    if (s_tuser == OP_FREE) begin
                        slot_next = SW'(s_tdata[FIELD_W-1:0]);
                        if (in_range) begin
                            ram_raddr     = slot_next[SW-1:BIT_W];
                            cur_addr_next = slot_next[SW-1:BIT_W];
                            state_next    = ST_FREE;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        ram_raddr     = cursor_reg[SW-1:BIT_W];
                        cur_addr_next = cursor_reg[SW-1:BIT_W];
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_FREE: begin
                ram_we      = 1'b1;
                ram_wdata   = ram_rdata & ~(ONE_BIT << slot_reg[BIT_W-1:0]);
                cursor_next = slot_reg;
                res_ok_next = 1'b1;
                state_next  = ST_OUT;
            end
            ST_SCAN: begin
                if (cand != '0) begin
                    ram_we        = 1'b1;
                    ram_wdata     = ram_rdata | (ONE_BIT << pos);
                    cursor_next   = (found_inc >= SLOT_COUNT_C) ? '0 : found_inc[SW-1:0];
                    res_slot_next = FIELD_W'(found_slot);
                    res_ok_next   = 1'b1;
                    res_hit_next  = (scan_cnt_reg == '0) && (pos == cur_bit);
                    state_next    = ST_OUT;
                end else if (scan_cnt_reg == WORDS_C) begin
                    state_next = ST_OUT;
                end else begin
                    ram_raddr     = wrap_addr;
                    cur_addr_next = wrap_addr;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, res_hit_reg, res_ok_reg, res_slot_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cursor_reg   <= cursor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        slot_reg     <= slot_next;
        cur_addr_reg <= cur_addr_next;
        scan_cnt_reg <= scan_cnt_next;
        res_slot_reg <= res_slot_next;
        res_ok_reg   <= res_ok_next;
        res_hit_reg  <= res_hit_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the next-fit slot allocator unit.
// ----------------------------------------------------------------------------
// Requests go in on the s_ stream and grants come back on the m_ stream. A
// shadow bitmap and cursor in the bench predict every grant. A short table
// covers the first grants after reset, frees of free slots, wrap of the
// cursor and the field extremes. Random traffic then churns the pool, fills
// it to exhaustion and keeps it near full. Both sides pause at random, and
// once the grant side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb;
    import nfsa_pkg::*;

    localparam int SLOTS = 1024;

    typedef struct packed {
        slot_field_t granted;
        logic        success;
        logic        hit;
    } grant_t;

    typedef struct {
        logic        op;
        slot_field_t slot;
        bit          typed;
        grant_t      want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    bit          slot_busy [SLOTS];
    slot_field_t cursor;
    int          busy_count;
    grant_t      pending_grants [$];
    int          mismatches;
    bit          calm;
    bit          hold_req;

    stim_row_t directed_rows [0:16] = '{
        '{OP_ALLOC, 10'd0,     1'b1, '{10'd0,    1'b1, 1'b1}},
        '{OP_ALLOC, 10'd1023,  1'b1, '{10'd1,    1'b1, 1'b1}},
        '{OP_FREE,  10'd1023,  1'b1, '{10'd0,    1'b1, 1'b0}},
        '{OP_ALLOC, 10'h2AA,   1'b1, '{10'd1023, 1'b1, 1'b1}},
        '{OP_ALLOC, 10'h155,   1'b0, '{10'd0,    1'b0, 1'b0}},
        '{OP_FREE,  10'd0,     1'b1, '{10'd0,    1'b1, 1'b0}},
        '{OP_ALLOC, 10'd0,     1'b1, '{10'd0,    1'b1, 1'b1}},
        '{OP_FREE,  10'd1,     1'b1, '{10'd0,    1'b1, 1'b0}},
        '{OP_FREE,  10'd2,     1'b1, '{10'd0,    1'b1, 1'b0}},
        '{OP_ALLOC, 10'd0,     1'b0, '{10'd0,    1'b0, 1'b0}},
        '{OP_ALLOC, 10'd1023,  1'b0, '{10'd0,    1'b0, 1'b0}},
        '{OP_FREE,  10'h2AA,   1'b1, '{10'd0,    1'b1, 1'b0}},
        '{OP_FREE,  10'h155,   1'b1, '{10'd0,    1'b1, 1'b0}},
        '{OP_ALLOC, 10'd0,     1'b0, '{10'd0,    1'b0, 1'b0}},
        '{OP_ALLOC, 10'd0,     1'b0, '{10'd0,    1'b0, 1'b0}},
        '{OP_FREE,  10'd3,     1'b1, '{10'd0,    1'b1, 1'b0}},
        '{OP_ALLOC, 10'd1023,  1'b0, '{10'd0,    1'b0, 1'b0}}
    };

    next_fit_slot_allocator_unit #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // shadow allocator: updates bitmap and cursor, returns the grant word
    function automatic grant_t predict_grant(input logic op, input slot_field_t slot);
        grant_t      g;
        slot_field_t start;
        int          idx;
        g = '0;
        if (op == OP_FREE) begin
            if (slot_busy[slot]) begin
                busy_count--;
            end
            slot_busy[slot] = 1'b0;
            cursor = slot;
            g.success = 1'b1;
        end else if (!slot_busy[cursor]) begin
            slot_busy[cursor] = 1'b1;
            busy_count++;
            g.granted = cursor;
            g.success = 1'b1;
            g.hit = 1'b1;
            cursor = slot_field_t'((int'(cursor) + 1) % SLOTS);
        end else begin
            start = cursor;
            for (int n = 1; n < SLOTS; n++) begin
                idx = (int'(start) + n) % SLOTS;
                if (!slot_busy[idx]) begin
                    slot_busy[idx] = 1'b1;
                    busy_count++;
                    g.granted = slot_field_t'(idx);
                    g.success = 1'b1;
                    cursor = slot_field_t'((idx + 1) % SLOTS);
                    break;
                end
            end
        end
        return g;
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic slot_field_t pick_busy_slot();
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int n = 0; n < SLOTS; n++) begin
            if (slot_busy[(start + n) % SLOTS]) begin
                return slot_field_t'((start + n) % SLOTS);
            end
        end
        return slot_field_t'(start);
    endfunction

    // drives one request and returns as soon as the unit has accepted it
    task automatic send_request(input logic op, input slot_field_t slot, input bit typed,
                                input grant_t want);
        int     gap;
        grant_t g;
        gap = pick_pause();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, slot};
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
        g = predict_grant(op, slot);
        pending_grants.push_back(typed ? want : g);
    endtask

    task automatic send_random(input int alloc_pct, input int any_slot_pct);
        slot_field_t slot;
        logic        op;
        op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
        if (op == OP_ALLOC || $urandom_range(0, 99) < any_slot_pct) begin
            slot = slot_field_t'($urandom_range(0, SLOTS - 1));
        end else begin
            slot = pick_busy_slot();
        end
        send_request(op, slot, 1'b0, '0);
    endtask

    task automatic check_word();
        grant_t want;
        if (pending_grants.size() == 0) begin
            $error("grant word with nothing pending: %h", m_tdata);
            mismatches++;
        end else begin
            want = pending_grants.pop_front();
            if (m_tdata[9:0] !== want.granted) begin
                $error("granted_slot: expected %0d, got %0d", want.granted, m_tdata[9:0]);
                mismatches++;
            end
            if (m_tdata[10] !== want.success) begin
                $error("success: expected %0b, got %0b", want.success, m_tdata[10]);
                mismatches++;
            end
            if (m_tdata[11] !== want.hit) begin
                $error("hit_at_cursor: expected %0b, got %0b", want.hit, m_tdata[11]);
                mismatches++;
            end
        end
    endtask

    // grant side: checks words and paces m_tready
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
                check_word();
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_pause();
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        mismatches = 0;
        busy_count = 0;
        cursor = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ALLOC;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].slot,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        // mixed churn at low occupancy
        for (int i = 0; i < 220; i++) begin
            if (i == 40) begin
                hold_req = 1'b1;
            end
            calm = (i >= 120 && i < 190);
            send_random(65, 20);
        end
        calm = 1'b0;

        // fill the pool, then knock on it while exhausted
        while (busy_count < SLOTS) begin
            send_random(100, 0);
        end
        repeat (8) send_random(100, 0);

        // churn near full: frees answered by hits, failures once full again
        for (int i = 0; i < 260; i++) begin
            calm = (i >= 100 && i < 160);
            send_random(55, 10);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
